### hdl/ppfbc_pkg.sv
package ppfbc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_TAP_ROWS    = 5;
    localparam int DEF_TAP_COLS    = 5;
    localparam int DEF_NUM_FILTERS = 16;
    localparam int DEF_MAX_ROWS    = 1024;

    // Fixed frame limit and quotient width
    localparam int MAX_COLS = 4096;
    localparam int QUOT_W   = 24;

    // Item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_PAD   = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pixel;
        logic [3:0]         filter_number;
        logic [2:0]         tap_row;
        logic [2:0]         tap_col;
        logic signed [15:0] coefficient;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] result_value;
        logic [9:0]         out_row;
        logic [11:0]        out_col;
        logic               zero_weight;
        logic               frame_last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic center_rd;
        logic filt;
        logic tap_rd;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic want_emit;
        logic tap_last;
        logic div_last;
        logic out_full;
    } status_t;

endpackage

### hdl/ppfbc_ctrl.sv
module ppfbc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  ppfbc_pkg::status_t sts,
    output ppfbc_pkg::cmd_t    cmd
);
    import ppfbc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_CENTER = 4'd2;
    localparam logic [3:0] S_FILT   = 4'd3;
    localparam logic [3:0] S_LOOP   = 4'd4;
    localparam logic [3:0] S_DRAIN  = 4'd5;
    localparam logic [3:0] S_DIVI   = 4'd6;
    localparam logic [3:0] S_DIVS   = 4'd7;
    localparam logic [3:0] S_PUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       drain_reg, drain_next;

    assign item_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = sts.want_emit ? S_CENTER : S_IDLE;
            end
            S_CENTER:
            begin
                cmd.center_rd = 1'b1;
                state_next    = S_FILT;
            end
            S_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                cmd.tap_rd = 1'b1;
                if (sts.tap_last)
                begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                    state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

endmodule

### hdl/ppfbc_dp.sv
module ppfbc_dp #(
    parameter int TAP_ROWS    = ppfbc_pkg::DEF_TAP_ROWS,
    parameter int TAP_COLS    = ppfbc_pkg::DEF_TAP_COLS,
    parameter int NUM_FILTERS = ppfbc_pkg::DEF_NUM_FILTERS,
    parameter int MAX_ROWS    = ppfbc_pkg::DEF_MAX_ROWS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ppfbc_pkg::in_item_t                   item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ppfbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppfbc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output ppfbc_pkg::out_item_t                  result,
    input  ppfbc_pkg::cmd_t                       cmd,
    output ppfbc_pkg::status_t                    sts
);
    import ppfbc_pkg::*;

    localparam int HR      = (TAP_ROWS - 1) / 2;
    localparam int HC      = (TAP_COLS - 1) / 2;
    localparam int TPF     = TAP_ROWS * TAP_COLS;
    localparam int RING    = TAP_COLS + 1;
    localparam int RING_W  = $clog2(RING);
    localparam int RW      = $clog2(MAX_ROWS);
    localparam int RW1     = RW + 1;
    localparam int CW      = 12;
    localparam int CW1     = 13;
    localparam int SA_N    = RING * MAX_ROWS;
    localparam int SA_W    = $clog2(SA_N);
    localparam int TA_N    = NUM_FILTERS * TPF;
    localparam int TA_W    = $clog2(TA_N + 1);
    localparam int TW      = 4;
    localparam int LIN_W   = CW1 + RW1;
    localparam int SUM_W   = 32 + $clog2(TPF + 1);
    localparam int WGT_W   = 16 + $clog2(TPF + 1);
    localparam int DV_W    = SUM_W + 8;
    localparam int DC_W    = $clog2(QUOT_W);
    localparam int ROWS_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

    localparam logic [CW1-1:0]    COLS_MAX  = CW1'(MAX_COLS);
    localparam logic [TW-1:0]     A_LAST    = TW'(2 * HR);
    localparam logic [TW-1:0]     B_LAST    = TW'(2 * HC);
    localparam logic [4:0]        NF_L      = 5'(NUM_FILTERS > 16 ? 16 : NUM_FILTERS);
    localparam logic [DC_W-1:0]   DIV_LAST  = DC_W'(QUOT_W - 1);

    // Memories
    logic [19:0]        col_mem [SA_N];
    logic signed [15:0] tap_mem [TA_N];

    // Frame size and stream position
    logic [RW1-1:0]    rows_reg;
    logic [CW1-1:0]    cols_reg;
    logic [RW-1:0]     in_row_reg, emit_row_reg;
    logic [CW-1:0]     in_col_reg, emit_col_reg;
    logic [RING_W-1:0] in_ring_reg, emit_ring_reg;
    logic [LIN_W-1:0]  pend_reg;
    logic [1:0]        kind_reg;

    // Window walk
    logic              f_ok_reg;
    logic [TA_W-1:0]   tap_base_reg, row_off_reg;
    logic [TW-1:0]     a_reg, b_reg;
    logic [19:0]       st_q_reg;
    logic signed [15:0] tp_q_reg;
    logic              v1_reg, v2_reg;
    logic signed [31:0] prod_reg;
    logic [16:0]       abs_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [WGT_W-1:0]  wgt_reg;

    // Divider
    logic              neg_reg;
    logic [WGT_W:0]    rem_reg;
    logic [QUOT_W-1:0] dvl_reg, q_reg;
    logic [DC_W-1:0]   dcnt_reg;

    // Output register
    logic              ov_reg;
    out_item_t         out_reg;

    assign cfg_ready    = 1'b1;
    assign result_valid = ov_reg;
    assign result       = out_reg;

    // Configuration value clamping
    logic [RW1+10:0] rows_cfg;
    logic [CW1-1:0]  cols_cfg;
    logic            cfg_we;
    always_comb
    begin
        rows_cfg = (RW1 + 11)'(cfg_data[10:0]);
        if (rows_cfg == '0)
            rows_cfg = (RW1 + 11)'(1);
        else if (rows_cfg > (RW1 + 11)'(MAX_ROWS))
            rows_cfg = (RW1 + 11)'(MAX_ROWS);
        cols_cfg = cfg_data;
        if (cols_cfg == '0)
            cols_cfg = CW1'(1);
        else if (cols_cfg > COLS_MAX)
            cols_cfg = COLS_MAX;
        cfg_we = cfg_valid && (cfg_index == REG_ROWS || cfg_index == REG_COLS);
    end

    // Input position advance
    logic              row_wrap, col_wrap;
    always_comb
    begin
        row_wrap = !((RW1'(in_row_reg) + RW1'(1)) < rows_reg);
        col_wrap = !((CW1'(in_col_reg) + CW1'(1)) < cols_reg);
    end

    // Emit decision
    logic [LIN_W-1:0] in_lin, lag;
    logic             want_emit;
    always_comb
    begin
        in_lin = LIN_W'(in_col_reg) * LIN_W'(rows_reg) + LIN_W'(in_row_reg);
        lag    = LIN_W'(HC * rows_reg);
        if ((rows_reg - RW1'(1)) > RW1'(HR))
            lag = lag + LIN_W'(HR);
        else
            lag = lag + LIN_W'(rows_reg - RW1'(1));
        want_emit = ((kind_reg == KIND_PIXEL) && (pend_reg > lag || pend_reg > in_lin))
                 || ((kind_reg == KIND_PAD) && pend_reg != '0 && pend_reg > in_lin);
    end

    // Tap load address
    logic            ld_ok;
    logic [TA_W-1:0] ld_addr;
    always_comb
    begin
        ld_ok = (5'(item.filter_number) < NF_L) && (4'(item.tap_row) < 4'(TAP_ROWS))
             && (4'(item.tap_col) < 4'(TAP_COLS));
        ld_addr = TA_W'(item.filter_number * TPF) + TA_W'(item.tap_row * TAP_COLS)
                + TA_W'(item.tap_col);
    end

    // Neighbour address and bounds
    logic [RW1-1:0]    r_ext;
    logic [CW1-1:0]    c_ext;
    logic              inb;
    logic [RING_W+1:0] ring_sum;
    logic [RING_W-1:0] ring_n;
    logic [SA_W-1:0]   st_addr, center_addr;
    logic [TA_W-1:0]   tp_addr;
    always_comb
    begin
        r_ext = RW1'(emit_row_reg) + RW1'(a_reg);
        c_ext = CW1'(emit_col_reg) + CW1'(b_reg);
        inb   = (r_ext >= RW1'(HR)) && ((r_ext - RW1'(HR)) < rows_reg)
             && (c_ext >= CW1'(HC)) && ((c_ext - CW1'(HC)) < cols_reg) && f_ok_reg;
        ring_sum = (RING_W + 2)'(emit_ring_reg) + (RING_W + 2)'(b_reg) + (RING_W + 2)'(RING - HC);
        if (ring_sum >= (RING_W + 2)'(RING))
            ring_sum = ring_sum - (RING_W + 2)'(RING);
        if (ring_sum >= (RING_W + 2)'(RING))
            ring_sum = ring_sum - (RING_W + 2)'(RING);
        ring_n      = ring_sum[RING_W-1:0];
        st_addr     = SA_W'(ring_n * MAX_ROWS) + SA_W'(r_ext[RW-1:0] - RW'(HR));
        center_addr = SA_W'(emit_ring_reg * MAX_ROWS) + SA_W'(emit_row_reg);
        tp_addr     = tap_base_reg + row_off_reg + TA_W'(b_reg);
        sts.want_emit = want_emit;
        sts.tap_last = (a_reg == A_LAST) && (b_reg == B_LAST);
        sts.div_last = (dcnt_reg == DIV_LAST);
        sts.out_full = ov_reg && !result_ready;
    end

    // Column store: write on pixel, read for the window
    always_ff @(posedge clk)
    begin
        if (cmd.take && item.kind == KIND_PIXEL)
            col_mem[SA_W'(in_ring_reg * MAX_ROWS) + SA_W'(in_row_reg)] <=
                {item.filter_number, item.pixel};
        if (cmd.center_rd)
            st_q_reg <= col_mem[center_addr];
        else if (cmd.tap_rd)
            st_q_reg <= col_mem[st_addr];
    end

    // Tap bank
    always_ff @(posedge clk)
    begin
        if (cmd.take && item.kind == KIND_LOAD && ld_ok)
            tap_mem[ld_addr] <= item.coefficient;
        if (cmd.tap_rd)
            tp_q_reg <= tap_mem[tp_addr];
    end

    // Stream counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= RW1'(ROWS_RST);
            cols_reg      <= CW1'(1024);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_ring_reg   <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_ring_reg <= '0;
            pend_reg      <= '0;
            kind_reg      <= KIND_LOAD;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ROWS)
                rows_reg <= rows_cfg[RW1-1:0];
            else
                cols_reg <= cols_cfg;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_ring_reg   <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_ring_reg <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                kind_reg <= item.kind;
                if (item.kind == KIND_PIXEL)
                begin
                    pend_reg <= pend_reg + LIN_W'(1);
                    if (!row_wrap)
                        in_row_reg <= in_row_reg + RW'(1);
                    else
                    begin
                        in_row_reg <= '0;
                        if (col_wrap)
                        begin
                            in_col_reg  <= '0;
                            in_ring_reg <= '0;
                        end
                        else
                        begin
                            in_col_reg  <= in_col_reg + CW'(1);
                            in_ring_reg <= (in_ring_reg == RING_W'(RING - 1)) ? '0
                                         : in_ring_reg + RING_W'(1);
                        end
                    end
                end
            end
            if (cmd.out_load)
            begin
                pend_reg <= pend_reg - LIN_W'(1);
                if ((RW1'(emit_row_reg) + RW1'(1)) < rows_reg)
                    emit_row_reg <= emit_row_reg + RW'(1);
                else
                begin
                    emit_row_reg <= '0;
                    if ((CW1'(emit_col_reg) + CW1'(1)) < cols_reg)
                    begin
                        emit_col_reg  <= emit_col_reg + CW'(1);
                        emit_ring_reg <= (emit_ring_reg == RING_W'(RING - 1)) ? '0
                                       : emit_ring_reg + RING_W'(1);
                    end
                    else
                    begin
                        emit_col_reg  <= '0;
                        emit_ring_reg <= '0;
                    end
                end
            end
        end
    end

    // Window walk counters and accumulation pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.tap_rd && inb;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.filt)
        begin
            f_ok_reg     <= 5'(st_q_reg[19:16]) < NF_L;
            tap_base_reg <= (5'(st_q_reg[19:16]) < NF_L) ? TA_W'(st_q_reg[19:16] * TPF) : '0;
            row_off_reg  <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            sum_reg      <= '0;
            wgt_reg      <= '0;
        end
        else
        begin
            if (cmd.tap_rd)
            begin
                if (b_reg == B_LAST)
                begin
                    b_reg       <= '0;
                    a_reg       <= a_reg + TW'(1);
                    row_off_reg <= row_off_reg + TA_W'(TAP_COLS);
                end
                else
                    b_reg <= b_reg + TW'(1);
            end
            if (v2_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(prod_reg);
                wgt_reg <= wgt_reg + WGT_W'(abs_reg);
            end
        end
        prod_reg <= $signed(st_q_reg[15:0]) * tp_q_reg;
        abs_reg  <= tp_q_reg[15] ? 17'(-$signed({tp_q_reg[15], tp_q_reg})) : 17'(tp_q_reg);
    end

    // Restoring divider of |sum| * 256 by the weight, one quotient bit a cycle
    logic [SUM_W-1:0] mag;
    logic [DV_W-1:0]  dv;
    logic [WGT_W:0]   rem_sh;
    always_comb
    begin
        mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        dv     = {mag, 8'd0};
        rem_sh = {rem_reg[WGT_W-1:0], dvl_reg[QUOT_W-1]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            neg_reg  <= sum_reg[SUM_W-1];
            rem_reg  <= (WGT_W + 1)'(dv >> QUOT_W);
            dvl_reg  <= dv[QUOT_W-1:0];
            q_reg    <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvl_reg  <= {dvl_reg[QUOT_W-2:0], 1'b0};
            dcnt_reg <= dcnt_reg + DC_W'(1);
            if (rem_sh >= {1'b0, wgt_reg})
            begin
                rem_reg <= rem_sh - {1'b0, wgt_reg};
                q_reg   <= {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (result_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (wgt_reg == '0)
                out_reg.result_value <= '0;
            else if (neg_reg)
                out_reg.result_value <= -$signed(q_reg);
            else if (q_reg[QUOT_W-1])
                out_reg.result_value <= 24'sh7FFFFF;
            else
                out_reg.result_value <= $signed(q_reg);
            out_reg.out_row     <= 10'(emit_row_reg);
            out_reg.out_col     <= emit_col_reg;
            out_reg.zero_weight <= (wgt_reg == '0);
            out_reg.frame_last  <= ((RW1'(emit_row_reg) + RW1'(1)) == rows_reg)
                                && ((CW1'(emit_col_reg) + CW1'(1)) == cols_reg);
        end
    end

endmodule

### hdl/per_pixel_filter_bank_convolution.sv
// Spatially variant 2-D convolution with weight normalization. Coefficient-load
// items fill the filter bank; pixel items stream one frame in column order and
// pad items drain the last outputs. An item that yields no result goes back to
// idle after the emit decision. For an item that yields a result, the single read
// port of the column store walks the window one tap per cycle, then a restoring
// divider forms one quotient bit per cycle. A finished result waits in the output
// register while the next item is taken. Configuration writes are always ready,
// and writes to the row or column register restart the stream position.
module per_pixel_filter_bank_convolution #(
    parameter int TAP_ROWS    = ppfbc_pkg::DEF_TAP_ROWS,
    parameter int TAP_COLS    = ppfbc_pkg::DEF_TAP_COLS,
    parameter int NUM_FILTERS = ppfbc_pkg::DEF_NUM_FILTERS,
    parameter int MAX_ROWS    = ppfbc_pkg::DEF_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  ppfbc_pkg::in_item_t              item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output ppfbc_pkg::out_item_t             result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ppfbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppfbc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppfbc_pkg::*;

    cmd_t    cmd;
    status_t sts;

    ppfbc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ppfbc_dp #(
        .TAP_ROWS    (TAP_ROWS),
        .TAP_COLS    (TAP_COLS),
        .NUM_FILTERS (NUM_FILTERS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ppfbc_pkg::*;

    localparam int WIN_R     = DEF_TAP_ROWS;
    localparam int WIN_C     = DEF_TAP_COLS;
    localparam int HALF_R    = (WIN_R - 1) / 2;
    localparam int HALF_C    = (WIN_C - 1) / 2;
    localparam int N_FILT    = DEF_NUM_FILTERS;
    localparam int RING_COLS = WIN_C + 1;
    localparam int WATCHDOG  = 5000;
    localparam int SETTLE    = 100;
    localparam int N_RANDOM  = 600;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    in_item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    per_pixel_filter_bank_convolution DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the block state
    logic [19:0] pixel_ring [RING_COLS * DEF_MAX_ROWS];
    int          filter_taps [N_FILT][WIN_R * WIN_C];
    int          frame_rows = 1024;
    int          frame_cols = 1024;
    int          in_row, in_col, out_row, out_col, held_pixels;

    out_item_t   expected_q [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    dir_row_t dir_tab [$];

    function automatic in_item_t mk(logic [1:0] k, int pix, int f, int tr, int tc, int coef);
        in_item_t it;
        it.kind          = k;
        it.pixel         = pix[15:0];
        it.filter_number = f[3:0];
        it.tap_row       = tr[2:0];
        it.tap_col       = tc[2:0];
        it.coefficient   = coef[15:0];
        return it;
    endfunction

    // Result of a 1x1 frame
    function automatic out_item_t single(int v, bit zw);
        out_item_t o;
        o.result_value = v[23:0];
        o.out_row      = '0;
        o.out_col      = '0;
        o.zero_weight  = zw;
        o.frame_last   = 1'b1;
        return o;
    endfunction

    function automatic void clear_stream();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        held_pixels = 0;
    endfunction

    function automatic void write_shadow_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        int v;
        if (idx == REG_ROWS)
        begin
            v = d[10:0];
            frame_rows = (v < 1) ? 1 : (v > DEF_MAX_ROWS) ? DEF_MAX_ROWS : v;
            clear_stream();
        end
        else if (idx == REG_COLS)
        begin
            v = d[12:0];
            frame_cols = (v < 1) ? 1 : (v > MAX_COLS) ? MAX_COLS : v;
            clear_stream();
        end
    endfunction

    // Normalized window sum for the oldest held pixel
    function automatic out_item_t convolve_oldest();
        out_item_t o;
        longint acc, wsum, q;
        int f, r, c, t, v;
        acc = 0;
        wsum = 0;
        q = 0;
        f = pixel_ring[(out_col % RING_COLS) * DEF_MAX_ROWS + out_row][3:0];
        for (int a = 0; a < 2 * HALF_R + 1; a++)
        begin
            for (int b = 0; b < 2 * HALF_C + 1; b++)
            begin
                r = out_row + a - HALF_R;
                c = out_col + b - HALF_C;
                if (r >= 0 && r < frame_rows && c >= 0 && c < frame_cols && f < N_FILT)
                begin
                    v = $signed(pixel_ring[(c % RING_COLS) * DEF_MAX_ROWS + r][19:4]);
                    t = filter_taps[f][a * WIN_C + b];
                    acc += longint'(v) * t;
                    wsum += (t < 0) ? -t : t;
                end
            end
        end
        if (wsum != 0)
        begin
            q = (acc * 256) / wsum;
            if (q > 8388607)
                q = 8388607;
            if (q < -8388608)
                q = -8388608;
        end
        o.result_value = q[23:0];
        o.out_row      = out_row[9:0];
        o.out_col      = out_col[11:0];
        o.zero_weight  = (wsum == 0);
        o.frame_last   = (out_row + 1 == frame_rows && out_col + 1 == frame_cols);
        if (out_row + 1 < frame_rows)
            out_row++;
        else
        begin
            out_row = 0;
            out_col = (out_col + 1 < frame_cols) ? out_col + 1 : 0;
        end
        held_pixels--;
        return o;
    endfunction

    // Advance the shadow state by one accepted item; returns 1 when a result is due
    function automatic bit filter_item(in_item_t it, output out_item_t o);
        int lag, lin;
        o = '0;
        lag = HALF_C * frame_rows + ((HALF_R < frame_rows - 1) ? HALF_R : frame_rows - 1);
        if (it.kind == KIND_LOAD)
        begin
            if (it.tap_row < WIN_R && it.tap_col < WIN_C && it.filter_number < N_FILT)
                filter_taps[it.filter_number][it.tap_row * WIN_C + it.tap_col] = it.coefficient;
            return 1'b0;
        end
        if (it.kind == KIND_PIXEL)
        begin
            pixel_ring[(in_col % RING_COLS) * DEF_MAX_ROWS + in_row] = {it.pixel, it.filter_number};
            if (in_row + 1 < frame_rows)
                in_row++;
            else
            begin
                in_row = 0;
                in_col = (in_col + 1 < frame_cols) ? in_col + 1 : 0;
            end
            held_pixels++;
            lin = in_col * frame_rows + in_row;
            if (held_pixels > lag || held_pixels > lin)
            begin
                o = convolve_oldest();
                return 1'b1;
            end
            return 1'b0;
        end
        if (it.kind == KIND_PAD)
        begin
            lin = in_col * frame_rows + in_row;
            if (held_pixels > 0 && held_pixels > lin)
            begin
                o = convolve_oldest();
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Offer one item, with random gaps ahead of it
    task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
        out_item_t o;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        if (filter_item(it, o))
            expected_q.push_back(typed ? want : o);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int d);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        write_shadow_reg(idx, d[CFG_DATA_W-1:0]);
    endtask

    function automatic in_item_t random_pixel();
        return mk(KIND_PIXEL, $urandom, $urandom_range(15), $urandom_range(7), $urandom_range(7),
                  $urandom);
    endfunction

    // Mostly whole frames; loads, spare kinds and early pads mixed in
    task automatic stream_frames(int nframes, bit cut_short, inout int count);
        int lag, n, total;
        total = nframes * frame_rows * frame_cols;
        if (cut_short)
            total = $urandom_range(1, total);
        for (n = 0; n < total; n++)
        begin
            case ($urandom_range(99))
                0, 1, 2, 3:
                begin
                    send_item(mk(KIND_LOAD, $urandom, $urandom_range(15), $urandom_range(7),
                                 $urandom_range(7), $urandom));
                    count++;
                end
                4:
                    send_item(mk(KIND_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom));
                5, 6:
                begin
                    send_item(mk(KIND_PAD, $urandom, $urandom, $urandom, $urandom, $urandom));
                    count++;
                end
                default: ;
            endcase
            send_item(random_pixel());
            count++;
        end
        if (!cut_short)
        begin
            lag = HALF_C * frame_rows + HALF_R;
            for (n = 0; n < lag + 2; n++)
            begin
                send_item(mk(KIND_PAD, $urandom, $urandom, $urandom, $urandom, $urandom));
                count++;
            end
        end
    endtask

    // Result checking, receiver stalls and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", result);
                end
                else
                begin
                    out_item_t e;
                    e = expected_q.pop_front();
                    if (result.result_value !== e.result_value || result.out_row !== e.out_row ||
                        result.out_col !== e.out_col || result.zero_weight !== e.zero_weight ||
                        result.frame_last !== e.frame_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", e, result);
                    end
                end
            end
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG);
                $display("[per_pixel_filter_bank_convolution] ERROR");
                $finish;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int phase, count, nfr;
        count = 0;
        clear_stream();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole bank; the last filter stays all zero
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 0);
        for (int f = 0; f < N_FILT; f++)
            for (int r = 0; r < WIN_R; r++)
                for (int c = 0; c < WIN_C; c++)
                    send_item(mk(KIND_LOAD, $urandom, f, r, c,
                                 (f == N_FILT - 1) ? 0 : $urandom));

        // Directed items on a 1x1 frame, where only the center tap counts
        dir_tab.push_back('{mk(KIND_LOAD, 0, 14, 2, 2, 32767), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_LOAD, 0, 13, 2, 2, -32768), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_PIXEL, -32768, 14, 0, 0, 0), 1'b1, single(-8388608, 0)});
        dir_tab.push_back('{mk(KIND_PIXEL, 32767, 14, 0, 0, 0), 1'b1, single(8388352, 0)});
        // Positive overflow saturates
        dir_tab.push_back('{mk(KIND_PIXEL, -32768, 13, 7, 7, -1), 1'b1, single(8388607, 0)});
        // All-zero filter gives the zero-weight flag
        dir_tab.push_back('{mk(KIND_PIXEL, 12345, 15, 0, 0, 0), 1'b1, single(0, 1)});
        // Loads outside the window are dropped
        dir_tab.push_back('{mk(KIND_LOAD, 0, 14, 7, 2, 0), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_LOAD, 0, 14, 2, 5, 0), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_LOAD, 0, 14, 5, 7, 0), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_PIXEL, 100, 14, 0, 0, 0), 1'b1, single(25600, 0)});
        dir_tab.push_back('{mk(KIND_SPARE, -1, 15, 7, 7, -1), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_PAD, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_PIXEL, 0, 13, 0, 0, 0), 1'b1, single(0, 0)});
        dir_tab.push_back('{mk(KIND_LOAD, 0, 0, 2, 2, 0), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_PIXEL, 777, 0, 0, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mk(KIND_PIXEL, -5, 3, 4, 4, 0), 1'b0, '0});
        foreach (dir_tab[i])
            send_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
        write_reg(REG_UNUSED, 8191);

        // Random frames of small sizes over the four idling modes
        phase = 0;
        while (count < N_RANDOM)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            write_reg(REG_ROWS, ($urandom_range(4) == 0) ? 1 : $urandom_range(1, 8));
            write_reg(REG_COLS, ($urandom_range(4) == 0) ? 1 : $urandom_range(1, 9));
            if (phase == 2)
            begin
                send_idle_pct = 0;
                stall_pct = 0;
                hold_request = 1'b1;
            end
            nfr = $urandom_range(1, 3);
            stream_frames(nfr, $urandom_range(6) == 0, count);
            if (phase == 5)
            begin
                drain_results();
                stream_frames(1, 1'b0, count);
            end
            phase++;
        end

        // Size extremes: out-of-range values clamp
        send_idle_pct = 0;
        stall_pct = 10;
        write_reg(REG_ROWS, 2047);
        write_reg(REG_COLS, 0);
        for (int n = 0; n < 8; n++)
            send_item(random_pixel());
        send_item(mk(KIND_PAD, 0, 0, 0, 0, 0));
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 8191);
        for (int n = 0; n < 40; n++)
            send_item(random_pixel());
        send_item(mk(KIND_PAD, 0, 0, 0, 0, 0));
        write_reg(REG_COLS, 4096);
        write_reg(REG_ROWS, 1024);

        drain_results();
        mismatches += expected_q.size();
        $display("ran %0d items over %0d frame-size phases, %0d results checked", items_sent,
                 phase, results_seen);
        if (mismatches == 0)
            $display("[per_pixel_filter_bank_convolution] OK");
        else
            $display("[per_pixel_filter_bank_convolution] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/ppfbc_pkg.sv
hdl/ppfbc_ctrl.sv
hdl/ppfbc_dp.sv
hdl/per_pixel_filter_bank_convolution.sv
tb/testbench.sv
